>>> design/abf_pkg.sv
// Package for the camera anchor blink follower: codes, constants and payload types.
// No dependencies; every other file of the block imports it.
package abf_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BLINK = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  // Fade phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OUT  = 2'd1;
  localparam logic [1:0] PH_IN   = 2'd2;

  // Follow modes
  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_BLINK  = 2'd1;
  localparam logic [1:0] MODE_ATTACH = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_FOLLOW_MODE = 1'd0;
  localparam logic [0:0] REG_DEAD_ZONE   = 1'd1;

  // Register reset values
  localparam logic [1:0]  FOLLOW_MODE_RESET = MODE_STATIC;
  localparam logic [11:0] DEAD_ZONE_RESET   = 12'd120;

  // Full black in Q16
  localparam logic [16:0] FADE_FULL = 17'd65536;

  // Fade step floor(dt * 65536 / 80000) = floor(dt * 512 / 625), taken as
  // (dt * ceil(2^35 / 625)) >> 26; exact for every 16-bit dt.
  localparam logic [25:0] STEP_RECIP = 26'd54975582;
  localparam int          STEP_SHIFT = 26;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        dt_us;
  } abf_item_t;

  typedef struct packed {
    logic [16:0]        fade_level;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [1:0]         fade_phase;
    logic               armed;
  } abf_result_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [11:0] value;
  } abf_cfg_wr_t;

  // Item held in the input register, with the fade step already worked out
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        step;
  } abf_staged_t;

  // Configuration as the core sees it
  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] r2;
    logic [29:0] r2_49;
  } abf_cfg_t;

endpackage

>>> design/abf_if.sv
// Handshake interfaces of the anchor blink follower: input items, results, configuration.
// Depends on abf_pkg for the payload types.
interface abf_item_if;
  import abf_pkg::*;
  logic      valid;
  logic      ready;
  abf_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abf_result_if;
  import abf_pkg::*;
  logic        valid;
  logic        ready;
  abf_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abf_cfg_if;
  import abf_pkg::*;
  logic        valid;
  logic        ready;
  abf_cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/abf_cfg_regs.sv
// Configuration registers of the anchor blink follower, with the squared dead zone
// radius precomputed. Depends on abf_pkg and abf_cfg_if.
module abf_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  abf_cfg_if.sink         cfg,
  output abf_pkg::abf_cfg_t cfg_out
);
  import abf_pkg::*;

  logic [1:0]  follow_mode;
  logic [23:0] r2;
  logic [29:0] r2_49;
  logic [23:0] r2_next;
  logic [29:0] r2_49_next;

  assign cfg.ready = 1'b1;

  // Square the written radius and scale by 49 so both land with the write
  assign r2_next    = 24'(cfg.data.value) * 24'(cfg.data.value);
  assign r2_49_next = (30'(r2_next) << 5) + (30'(r2_next) << 4) + 30'(r2_next);

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      follow_mode <= FOLLOW_MODE_RESET;
      r2          <= 24'(DEAD_ZONE_RESET) * 24'(DEAD_ZONE_RESET);
      r2_49       <= 30'd49 * 30'(DEAD_ZONE_RESET) * 30'(DEAD_ZONE_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_FOLLOW_MODE: follow_mode <= cfg.data.value[1:0];
        REG_DEAD_ZONE: begin
          r2    <= r2_next;
          r2_49 <= r2_49_next;
        end
        default: ;
      endcase
    end
  end

  assign cfg_out.mode  = follow_mode;
  assign cfg_out.r2    = r2;
  assign cfg_out.r2_49 = r2_49;
endmodule

>>> design/abf_in_stage.sv
// Input register of the anchor blink follower; works out the fade step on the way in.
// Depends on abf_pkg and abf_item_if.
module abf_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  abf_item_if.sink             items,
  input  logic                 adv,
  output logic                 stage_vld,
  output abf_pkg::abf_staged_t staged
);
  import abf_pkg::*;

  logic [41:0] step_prod;

  // Reciprocal multiply for the step
  assign step_prod = 42'(items.data.dt_us) * 42'(STEP_RECIP);

  // Take a new transaction whenever the register is empty or the held one moves on
  assign items.ready = !stage_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
    end else if (items.ready) begin
      stage_vld <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      staged.operation <= items.data.operation;
      staged.pos_x     <= items.data.pos_x;
      staged.pos_y     <= items.data.pos_y;
      staged.step      <= step_prod[STEP_SHIFT +: 16];
    end
  end
endmodule

>>> design/abf_core.sv
// Anchor state and single-pass update of the anchor blink follower, with the result
// data register. Depends on abf_pkg.
module abf_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  abf_pkg::abf_staged_t staged,
  input  abf_pkg::abf_cfg_t    cfg_in,
  output abf_pkg::abf_result_t result
);
  import abf_pkg::*;

  logic signed [15:0] anchor_x, anchor_z, pending_x, pending_z;
  logic [16:0]        fade_amount;
  logic [1:0]         phase;
  logic               rearmed;

  logic signed [15:0] anchor_x_next, anchor_z_next, pending_x_next, pending_z_next;
  logic [16:0]        fade_amount_next;
  logic [1:0]         phase_next;
  logic               rearmed_next;

  logic signed [16:0] dx, dz;
  logic signed [33:0] sq_x, sq_z;
  logic [32:0]        d2;
  logic [39:0]        d2_100;
  logic               near, far;
  logic [17:0]        lv_sum;

  // Squared distance from the origin and the dead zone tests
  assign dx     = {staged.pos_x[15], staged.pos_x} - {anchor_x[15], anchor_x};
  assign dz     = {staged.pos_y[15], staged.pos_y} - {anchor_z[15], anchor_z};
  assign sq_x   = dx * dx;
  assign sq_z   = dz * dz;
  assign d2     = 33'(sq_x[31:0]) + 33'(sq_z[31:0]);
  assign d2_100 = (40'(d2) << 6) + (40'(d2) << 5) + (40'(d2) << 2);
  assign near   = d2_100 < 40'(cfg_in.r2_49);
  assign far    = d2 > 33'(cfg_in.r2);
  assign lv_sum = 18'(fade_amount) + 18'(staged.step);

  // Next state for the held transaction
  always_comb begin
    logic arm_tmp;
    arm_tmp          = rearmed || near;
    anchor_x_next    = anchor_x;
    anchor_z_next    = anchor_z;
    pending_x_next   = pending_x;
    pending_z_next   = pending_z;
    fade_amount_next = fade_amount;
    phase_next       = phase;
    rearmed_next     = rearmed;
    unique case (staged.operation)
      OP_TICK: begin
        if (phase == PH_OUT) begin
          // Fade out; jump the origin at full black
          if (lv_sum >= 18'(FADE_FULL)) begin
            fade_amount_next = FADE_FULL;
            anchor_x_next    = pending_x;
            anchor_z_next    = pending_z;
            phase_next       = PH_IN;
            rearmed_next     = 1'b0;
          end else begin
            fade_amount_next = lv_sum[16:0];
          end
        end else if (phase == PH_IN) begin
          // Fade back in and settle at zero
          if (17'(staged.step) >= fade_amount) begin
            fade_amount_next = '0;
            phase_next       = PH_IDLE;
          end else begin
            fade_amount_next = fade_amount - 17'(staged.step);
          end
        end else if (cfg_in.mode == MODE_BLINK) begin
          // Re-arm inside the inner zone, blink on leaving the dead zone
          rearmed_next = arm_tmp;
          if (arm_tmp && far) begin
            pending_x_next   = staged.pos_x;
            pending_z_next   = staged.pos_y;
            phase_next       = PH_OUT;
            fade_amount_next = '0;
          end
        end else if (cfg_in.mode == MODE_ATTACH) begin
          anchor_x_next = staged.pos_x;
          anchor_z_next = staged.pos_y;
        end
      end
      OP_BLINK: begin
        // Drop the request while a fade runs
        if (phase == PH_IDLE) begin
          pending_x_next   = staged.pos_x;
          pending_z_next   = staged.pos_y;
          phase_next       = PH_OUT;
          fade_amount_next = '0;
        end
      end
      OP_SET: begin
        anchor_x_next = staged.pos_x;
        anchor_z_next = staged.pos_y;
        rearmed_next  = 1'b1;
      end
      default: ;
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x    <= '0;
      anchor_z    <= '0;
      pending_x   <= '0;
      pending_z   <= '0;
      fade_amount <= '0;
      phase       <= PH_IDLE;
      rearmed     <= 1'b1;
    end else if (fire) begin
      anchor_x    <= anchor_x_next;
      anchor_z    <= anchor_z_next;
      pending_x   <= pending_x_next;
      pending_z   <= pending_z_next;
      fade_amount <= fade_amount_next;
      phase       <= phase_next;
      rearmed     <= rearmed_next;
    end
  end

  // Capture the result of the transaction
  always_ff @(posedge clk) begin
    if (fire) begin
      result.fade_level <= fade_amount_next;
      result.origin_x   <= anchor_x_next;
      result.origin_y   <= anchor_z_next;
      result.fade_phase <= phase_next;
      result.armed      <= rearmed_next;
    end
  end
endmodule

>>> design/anchor_blink_follow.sv
// Camera anchor follower with blink fade: one result transaction for every input
// transaction, giving fade level, origin, phase and arm flag after that item. Throughput
// is one item per cycle while the result consumer keeps ready high; each item passes
// the input register, the single-pass state update and then the result register. A
// configuration write applies to every item processed after it; write only while no
// item is in flight.
// Depends on abf_pkg, abf_if, abf_cfg_regs, abf_in_stage and abf_core.
module anchor_blink_follow (
  input  logic       clk,
  input  logic       rst,
  abf_item_if.sink   items,
  abf_result_if.source results,
  abf_cfg_if.sink    cfg
);
  import abf_pkg::*;

  abf_cfg_t    cfg_cur;
  abf_staged_t staged;
  logic        stage_vld;
  logic        adv;
  logic        fire;
  logic        res_vld;

  abf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_cur)
  );

  abf_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .adv       (adv),
    .stage_vld (stage_vld),
    .staged    (staged)
  );

  abf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .staged (staged),
    .cfg_in (cfg_cur),
    .result (results.data)
  );

  // Advance when the result register is free or being emptied
  assign adv  = !res_vld || results.ready;
  assign fire = stage_vld && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= stage_vld;
    end
  end

  assign results.valid = res_vld;
endmodule

>>> design/abf_checker.sv
// Port-level assertions for the anchor blink follower, bound to the top level.
// Depends on abf_pkg and anchor_blink_follow.
module abf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input abf_pkg::abf_result_t res_data
);
  import abf_pkg::*;

  // Level never passes full black
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.fade_level <= FADE_FULL)
    else $error("fade level above full black");

  // Idle means fully faded in
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.fade_phase == PH_IDLE) |-> res_data.fade_level == 17'd0)
    else $error("idle phase with non-zero fade level");

  // Reaching full black always hands over to fade-in
  a_out_below_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.fade_phase == PH_OUT) |-> res_data.fade_level < FADE_FULL)
    else $error("fade-out reported at full black");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");
endmodule

bind anchor_blink_follow abf_checker u_abf_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_data  (results.data)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the camera anchor blink follower: directed and random item streams.
// Depends on abf_pkg, the abf_if handshake interfaces and the anchor_blink_follow top level.
module testbench;
  import abf_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam longint FADE_SPAN_US   = 80000;
  localparam int     SQUEEZE_CYCLES = 400;
  localparam int     QUIET_LIMIT    = 2000;
  localparam int     DRAIN_TAIL     = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Driven copies of the block inputs, known from time zero
  logic        send_valid = 1'b0;
  abf_item_t   send_item  = '0;
  logic        take_ready = 1'b0;
  logic        reg_valid  = 1'b0;
  abf_cfg_wr_t reg_write  = '0;

  abf_item_if   item_ch ();
  abf_result_if result_ch ();
  abf_cfg_if    cfg_ch ();

  assign item_ch.valid   = send_valid;
  assign item_ch.data    = send_item;
  assign result_ch.ready = take_ready;
  assign cfg_ch.valid    = reg_valid;
  assign cfg_ch.data     = reg_write;

  anchor_blink_follow dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // Predicted anchor state and configuration
  logic signed [15:0] anc_x  = '0;
  logic signed [15:0] anc_z  = '0;
  logic signed [15:0] pend_x = '0;
  logic signed [15:0] pend_z = '0;
  logic [16:0]        fade   = '0;
  logic [1:0]         ph     = PH_IDLE;
  logic               arm    = 1'b1;
  logic [1:0]         mode_q = FOLLOW_MODE_RESET;
  logic [11:0]        dz_q   = DEAD_ZONE_RESET;

  abf_item_t   item_backlog[$];
  abf_result_t predicted_views[$];

  int items_queued   = 0;
  int items_taken    = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit squeeze_req    = 1'b0;
  bit squeeze_done   = 1'b0;
  int squeeze_count  = 0;

  // Player random walk for the generated stream
  logic signed [15:0] walk_x = '0;
  logic signed [15:0] walk_y = '0;
  int                 walk_span = 120;

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance the predicted state by one item and return the view after it
  function automatic abf_result_t advance_anchor(input abf_item_t it);
    logic [31:0] step;
    logic [31:0] level;
    longint      dx, dz, d2, r2;
    abf_result_t view;
    step = 32'((64'(it.dt_us) << 16) / FADE_SPAN_US);
    case (it.operation)
      OP_TICK: begin
        if (ph == PH_OUT) begin
          level = 32'(fade) + step;
          if (level >= 32'(FADE_FULL)) begin
            fade = FADE_FULL;
            anc_x = pend_x;
            anc_z = pend_z;
            ph = PH_IN;
            arm = 1'b0;
          end else begin
            fade = level[16:0];
          end
        end else if (ph == PH_IN) begin
          if (step >= 32'(fade)) begin
            fade = '0;
            ph = PH_IDLE;
          end else begin
            fade = fade - step[16:0];
          end
        end else if (mode_q == MODE_BLINK) begin
          // Dead zone with hysteresis: re-arm inside 0.7 r, blink outside r
          dx = longint'($signed(it.pos_x)) - longint'(anc_x);
          dz = longint'($signed(it.pos_y)) - longint'(anc_z);
          d2 = dx * dx + dz * dz;
          r2 = longint'(dz_q) * longint'(dz_q);
          if (!arm && 100 * d2 < 49 * r2) arm = 1'b1;
          if (arm && d2 > r2) begin
            pend_x = it.pos_x;
            pend_z = it.pos_y;
            ph = PH_OUT;
            fade = '0;
          end
        end else if (mode_q == MODE_ATTACH) begin
          anc_x = it.pos_x;
          anc_z = it.pos_y;
        end
      end
      OP_BLINK: begin
        if (ph == PH_IDLE) begin
          pend_x = it.pos_x;
          pend_z = it.pos_y;
          ph = PH_OUT;
          fade = '0;
        end
      end
      OP_SET: begin
        anc_x = it.pos_x;
        anc_z = it.pos_y;
        arm = 1'b1;
      end
      default: ;
    endcase
    view.fade_level = fade;
    view.origin_x   = anc_x;
    view.origin_y   = anc_z;
    view.fade_phase = ph;
    view.armed      = arm;
    return view;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Item driver: offer from the backlog, predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
    end else begin
      if (send_valid && item_ch.ready) begin
        predicted_views.push_back(advance_anchor(send_item));
        items_taken++;
      end
      if (!send_valid || item_ch.ready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          send_valid <= 1'b1;
          send_item  <= item_backlog.pop_front();
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      take_ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      take_ready <= 1'b0;
      squeeze_count <= squeeze_count + 1;
      if (squeeze_count == SQUEEZE_CYCLES - 1) squeeze_done <= 1'b1;
    end else begin
      take_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    abf_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (predicted_views.size() == 0) begin
        $display("%0t ns: result with none predicted, expected nothing, actual fade %0d origin (%0d,%0d)",
                 $time, result_ch.data.fade_level, result_ch.data.origin_x,
                 result_ch.data.origin_y);
        mismatches++;
      end else begin
        want = predicted_views.pop_front();
        check_field("fade_level", want.fade_level, result_ch.data.fade_level);
        check_field("origin_x", want.origin_x, result_ch.data.origin_x);
        check_field("origin_y", want.origin_y, result_ch.data.origin_y);
        check_field("fade_phase", want.fade_phase, result_ch.data.fade_phase);
        check_field("armed", want.armed, result_ch.data.armed);
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transaction anywhere
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("anchor_blink_follow regression: fail");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] op, input int x, input int y,
                            input logic [15:0] dt);
    item_backlog.push_back('{operation: op, pos_x: 16'(x), pos_y: 16'(y), dt_us: dt});
    items_queued++;
  endtask

  // Wait until every item is taken and every result checked, then let the pipe settle
  task automatic drain();
    while (items_taken != items_queued || predicted_views.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [11:0] wdata);
    @(posedge clk);
    reg_valid <= 1'b1;
    reg_write <= '{index: idx, value: wdata};
    do @(posedge clk); while (!cfg_ch.ready);
    reg_valid <= 1'b0;
    if (idx == REG_FOLLOW_MODE) mode_q = wdata[1:0];
    else dz_q = wdata;
  endtask

  task automatic configure(input logic [1:0] mode, input logic [11:0] radius,
                           input int idle, input int stall);
    drain();
    write_reg(REG_FOLLOW_MODE, {10'd0, mode});
    write_reg(REG_DEAD_ZONE, radius);
    repeat (2) @(posedge clk);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    walk_span      = (radius < 16) ? 16 : int'(radius);
  endtask

  // Mostly ticks along a wandering player, with blinks, origin writes and noise
  task automatic queue_random(input int count);
    int          pick;
    int          reach;
    logic [15:0] dt;
    for (int n = 0; n < count; n++) begin
      reach  = ($urandom_range(9) == 0) ? 2 * walk_span : walk_span / 3 + 1;
      walk_x = walk_x + 16'(int'($urandom_range(2 * reach)) - reach);
      walk_y = walk_y + 16'(int'($urandom_range(2 * reach)) - reach);
      pick = $urandom_range(99);
      if (pick < 5) dt = 16'd0;
      else if (pick < 10) dt = 16'hFFFF;
      else if (pick < 25) dt = 16'($urandom);
      else dt = 16'($urandom_range(30000, 4000));
      pick = $urandom_range(99);
      if (pick < 8) queue_item(2'($urandom), $urandom, $urandom, 16'($urandom));
      else if (pick < 18) queue_item(OP_BLINK, walk_x, walk_y, dt);
      else if (pick < 26) queue_item(OP_SET, walk_x, walk_y, dt);
      else if (pick < 30) queue_item(OP_UNUSED, walk_x, walk_y, dt);
      else queue_item(OP_TICK, walk_x, walk_y, dt);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: zero ticks, unused code, extreme origins, full fade cycle
    queue_item(OP_TICK, 0, 0, 16'd0);
    queue_item(OP_UNUSED, 5, 5, 16'd5);
    queue_item(OP_SET, 32767, -32768, 16'd0);
    queue_item(OP_BLINK, -32768, 32767, 16'd0);
    queue_item(OP_TICK, 0, 0, 16'd0);
    queue_item(OP_BLINK, 1, 1, 16'd0);
    queue_item(OP_TICK, 0, 0, 16'hFFFF);
    queue_item(OP_SET, 100, -100, 16'd0);
    queue_item(OP_TICK, 0, 0, 16'hFFFF);
    queue_item(OP_TICK, 0, 0, 16'd0);
    queue_item(OP_TICK, 0, 0, 16'hFFFF);
    queue_item(OP_BLINK, 2, 2, 16'd0);
    queue_item(OP_TICK, 0, 0, 16'hFFFF);

    // Blink mode: dead zone edge, blink, no re-arm when far, re-arm boundary
    configure(MODE_BLINK, 12'd120, 0, 0);
    queue_item(OP_SET, 0, 0, 16'd0);
    queue_item(OP_TICK, 50, 50, 16'd20000);
    queue_item(OP_TICK, 120, 0, 16'd20000);
    queue_item(OP_TICK, 121, 0, 16'd20000);
    repeat (4) queue_item(OP_TICK, 0, 0, 16'hFFFF);
    queue_item(OP_TICK, 321, 0, 16'd20000);
    queue_item(OP_TICK, 205, 0, 16'd20000);
    queue_item(OP_TICK, 204, 0, 16'd20000);
    queue_item(OP_TICK, 421, 0, 16'd20000);

    // Attached mode at the extremes, then the unused mode
    configure(MODE_ATTACH, 12'd4095, 0, 0);
    queue_item(OP_TICK, -32768, 32767, 16'hFFFF);
    configure(MODE_UNUSED, 12'd4095, 0, 0);
    queue_item(OP_TICK, 7, 7, 16'd1000);

    // Random phases across settings and idling patterns
    configure(MODE_BLINK, 12'd120, 0, 0);
    queue_random(200);
    configure(MODE_ATTACH, 12'd0, 63, 0);
    queue_random(120);
    configure(MODE_BLINK, 12'd4095, 0, 63);
    queue_random(150);
    configure(MODE_BLINK, 12'($urandom_range(400, 20)), 16, 16);
    squeeze_req = 1'b1;
    queue_random(150);
    configure(MODE_STATIC, 12'($urandom), 0, 0);
    queue_random(100);
    configure(MODE_UNUSED, 12'd60, 63, 0);
    queue_random(100);
    configure(MODE_BLINK, 12'd0, 0, 63);
    queue_random(180);

    drain();
    if (mismatches == 0) begin
      $display("anchor_blink_follow regression: pass");
    end else begin
      $display("anchor_blink_follow regression: fail");
    end
    $finish;
  end

endmodule
